@@ hw/rtl/position_packet_checker_defines.svh @@
// Assertion macros for the position packet checker.
// PPC_ASSERT checks a property outside reset; PPC_ASSERT_ALWAYS checks it at every edge.
`ifndef POSITION_PACKET_CHECKER_DEFINES_SVH
`define POSITION_PACKET_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPC_ASSERT(lbl, prop, msg)
`define PPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/ppc_pkg.sv @@
package ppc_pkg;

    localparam int FRAME_BYTES_DEFAULT = 32;

    // frame layout
    localparam int HEADER_LEN  = 5;
    localparam int X_FIRST     = 9;
    localparam int Y_FIRST     = 13;
    localparam int Z_LAST      = 20;
    localparam int SHORT_SPAN  = 23;
    localparam int LONG_SPAN   = 29;

    localparam logic [7:0] HDR_SYNC    = 8'hff;
    localparam logic [7:0] HDR_ADDR    = 8'h47;
    localparam logic [7:0] TYPE_LO_A   = 8'h01;
    localparam logic [7:0] TYPE_LO_B   = 8'h11;
    localparam logic [7:0] TYPE_HI     = 8'h00;
    localparam logic [7:0] SIZE_CM     = 8'h10;
    localparam logic [7:0] SIZE_MM     = 8'h16;

    localparam logic [15:0] CRC_INIT   = 16'hffff;
    localparam logic [15:0] CRC_POLY   = 16'ha001;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_TYPE   = 3'd2,
        ST_SIZE   = 3'd3,
        ST_CRC    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] pos_x_mm;
        logic signed [31:0] pos_y_mm;
        logic signed [31:0] pos_z_mm;
        logic               position_fresh;
        logic               position_valid;
        logic [7:0]         offending_byte;
        logic [31:0]        failure_count;
    } result_t;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // cm to mm: v * 10 as shift and add
    function automatic logic [31:0] times_ten(logic [15:0] v);
        return {13'd0, v, 3'd0} + {15'd0, v, 1'd0};
    endfunction

endpackage

@@ hw/rtl/position_packet_checker.sv @@
// A frame's result is registered into the output register, or into the skid entry while the output is held.
// Throughput: one byte per cycle while byte_stall is low; one result per frame of FRAME_BYTES bytes.
// A two-entry output queue (output register plus skid) lets bytes keep flowing while
// a result waits; byte_stall rises only while both entries are full.
// Reset (rst_n low, asynchronous): frame position, CRC, flags, committed positions,
// fail counter and the output queue clear at once; no clearing pass.
`include "position_packet_checker_defines.svh"

module position_packet_checker #(
    parameter int FRAME_BYTES = ppc_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  ppc_pkg::byte_item_t byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output ppc_pkg::result_t    result
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_SHORT      = IDX_W'(ppc_pkg::SHORT_SPAN - 1);
    localparam logic [IDX_W-1:0] IDX_LONG       = IDX_W'(ppc_pkg::LONG_SPAN - 1);
    localparam logic [IDX_W-1:0] IDX_HDR_END    = IDX_W'(ppc_pkg::HEADER_LEN);
    localparam logic [IDX_W-1:0] IDX_X_FIRST    = IDX_W'(ppc_pkg::X_FIRST);
    localparam logic [IDX_W-1:0] IDX_Y_FIRST    = IDX_W'(ppc_pkg::Y_FIRST);
    localparam logic [IDX_W-1:0] IDX_Z_FIRST    = IDX_W'(ppc_pkg::Y_FIRST + 4);
    localparam logic [IDX_W-1:0] IDX_Z_LAST     = IDX_W'(ppc_pkg::Z_LAST);

    // frame tracking and CRC
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_value_reg, crc_value_next;
    logic             crc_ok_short_reg, crc_ok_short_next;
    logic             crc_ok_long_reg, crc_ok_long_next;

    // captured frame fields (written every frame before use, no reset)
    logic [7:0]  header_reg [ppc_pkg::HEADER_LEN];
    logic [7:0]  header_next [ppc_pkg::HEADER_LEN];
    logic [31:0] staged_x_reg, staged_x_next;
    logic [31:0] staged_y_reg, staged_y_next;
    logic [31:0] staged_z_reg, staged_z_next;

    // committed results
    logic [31:0] committed_x_reg, committed_x_next;
    logic [31:0] committed_y_reg, committed_y_next;
    logic [31:0] committed_z_reg, committed_z_next;
    logic        valid_flag_reg, valid_flag_next;
    logic [7:0]  fail_byte_reg, fail_byte_next;
    logic [31:0] fail_count_reg, fail_count_next;

    // output queue
    logic              out_valid_reg, out_valid_next;
    ppc_pkg::result_t  out_item_reg, out_item_next;
    logic              skid_valid_reg, skid_valid_next;
    ppc_pkg::result_t  skid_item_reg, skid_item_next;

    logic              accept;
    logic              out_take;
    logic [IDX_W-1:0]  idx;
    logic              is_last;
    logic [15:0]       crc_upd;
    logic [1:0]        lane;
    logic              res_valid;
    ppc_pkg::result_t  res_item;
    ppc_pkg::status_t  status;
    logic              fresh;

    // Stall the byte side only when both queue entries hold results.
    assign byte_stall   = skid_valid_reg;
    assign accept       = byte_valid && !byte_stall;
    assign out_take     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // A start flag forces byte 0; otherwise continue the running frame position.
    assign idx     = byte_item.frame_start ? '0 : byte_index_reg;
    assign is_last = (idx == IDX_LAST);
    assign crc_upd = ppc_pkg::crc_byte((idx == '0) ? ppc_pkg::CRC_INIT : crc_value_reg,
                                       byte_item.data_byte);
    // Position words start at bytes 9, 13, 17: all one above a multiple of four.
    assign lane    = idx[1:0] - 2'd1;

    // Frame capture and CRC tracking.
    always_comb
    begin
        byte_index_next   = byte_index_reg;
        crc_value_next    = crc_value_reg;
        crc_ok_short_next = crc_ok_short_reg;
        crc_ok_long_next  = crc_ok_long_reg;
        header_next       = header_reg;
        staged_x_next     = staged_x_reg;
        staged_y_next     = staged_y_reg;
        staged_z_next     = staged_z_reg;
        if (accept)
        begin
            crc_value_next  = crc_upd;
            byte_index_next = is_last ? '0 : idx + IDX_W'(1);
            if (idx == '0)
            begin
                crc_ok_short_next = 1'b0;
                crc_ok_long_next  = 1'b0;
            end
            // The spans include the received CRC bytes, so zero means good.
            if (idx == IDX_SHORT)
            begin
                crc_ok_short_next = (crc_upd == 16'd0);
            end
            if (idx == IDX_LONG)
            begin
                crc_ok_long_next = (crc_upd == 16'd0);
            end
            priority if (idx < IDX_HDR_END)
            begin
                header_next[idx[2:0]] = byte_item.data_byte;
            end
            else if (idx >= IDX_X_FIRST && idx < IDX_Y_FIRST)
            begin
                staged_x_next[{lane, 3'b000} +: 8] = byte_item.data_byte;
            end
            else if (idx >= IDX_Y_FIRST && idx < IDX_Z_FIRST)
            begin
                staged_y_next[{lane, 3'b000} +: 8] = byte_item.data_byte;
            end
            else if (idx >= IDX_Z_FIRST && idx <= IDX_Z_LAST)
            begin
                staged_z_next[{lane, 3'b000} +: 8] = byte_item.data_byte;
            end
            else
            begin
                // payload bytes that carry nothing of interest
            end
        end
    end

    // Frame check on the last byte. All fields it reads are already registered.
    always_comb
    begin
        committed_x_next = committed_x_reg;
        committed_y_next = committed_y_reg;
        committed_z_next = committed_z_reg;
        valid_flag_next  = valid_flag_reg;
        fail_byte_next   = fail_byte_reg;
        fail_count_next  = fail_count_reg;
        status           = ppc_pkg::ST_OK;
        fresh            = 1'b0;
        res_valid        = accept && is_last;

        if (res_valid)
        begin
            priority if (header_reg[0] != ppc_pkg::HDR_SYNC
                         || header_reg[1] != ppc_pkg::HDR_ADDR)
            begin
                status         = ppc_pkg::ST_HEADER;
                fail_byte_next = header_reg[1];
            end
            else if (!(header_reg[2] == ppc_pkg::TYPE_LO_A || header_reg[2] == ppc_pkg::TYPE_LO_B)
                     || header_reg[3] != ppc_pkg::TYPE_HI)
            begin
                status         = ppc_pkg::ST_TYPE;
                fail_byte_next = header_reg[2];
            end
            else if (header_reg[4] == ppc_pkg::SIZE_CM)
            begin
                if (crc_ok_short_reg)
                begin
                    committed_x_next = ppc_pkg::times_ten(staged_x_reg[15:0]);
                    committed_y_next = ppc_pkg::times_ten(staged_x_reg[31:16]);
                    committed_z_next = ppc_pkg::times_ten(staged_y_reg[15:0]);
                    fresh            = 1'b1;
                end
                else
                begin
                    status = ppc_pkg::ST_CRC;
                end
            end
            else if (header_reg[4] == ppc_pkg::SIZE_MM)
            begin
                if (crc_ok_long_reg)
                begin
                    committed_x_next = staged_x_reg;
                    committed_y_next = staged_y_reg;
                    committed_z_next = staged_z_reg;
                    fresh            = 1'b1;
                end
                else
                begin
                    status = ppc_pkg::ST_CRC;
                end
            end
            else
            begin
                status         = ppc_pkg::ST_SIZE;
                fail_byte_next = header_reg[4];
            end

            if (fresh)
            begin
                valid_flag_next = 1'b1;
            end
            // saturate rather than wrap
            if (status != ppc_pkg::ST_OK && fail_count_reg != '1)
            begin
                fail_count_next = fail_count_reg + 32'd1;
            end
        end

        res_item.status         = status;
        res_item.pos_x_mm       = committed_x_next;
        res_item.pos_y_mm       = committed_y_next;
        res_item.pos_z_mm       = committed_z_next;
        res_item.position_fresh = fresh;
        res_item.position_valid = valid_flag_next;
        res_item.offending_byte = fail_byte_next;
        res_item.failure_count  = fail_count_next;
    end

    // Output queue: the skid entry drains into the output register first.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_item_next  = res_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = res_item;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            crc_value_reg    <= ppc_pkg::CRC_INIT;
            crc_ok_short_reg <= 1'b0;
            crc_ok_long_reg  <= 1'b0;
            committed_x_reg  <= '0;
            committed_y_reg  <= '0;
            committed_z_reg  <= '0;
            valid_flag_reg   <= 1'b0;
            fail_byte_reg    <= '0;
            fail_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            crc_value_reg    <= crc_value_next;
            crc_ok_short_reg <= crc_ok_short_next;
            crc_ok_long_reg  <= crc_ok_long_next;
            committed_x_reg  <= committed_x_next;
            committed_y_reg  <= committed_y_next;
            committed_z_reg  <= committed_z_next;
            valid_flag_reg   <= valid_flag_next;
            fail_byte_reg    <= fail_byte_next;
            fail_count_reg   <= fail_count_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg    <= header_next;
        staged_x_reg  <= staged_x_next;
        staged_y_reg  <= staged_y_next;
        staged_z_reg  <= staged_z_next;
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    `PPC_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full with empty output")
    `PPC_ASSERT(a_index_in_frame, byte_index_reg <= IDX_LAST, "frame position out of range")
    `PPC_ASSERT(a_valid_sticky, valid_flag_reg |=> valid_flag_reg, "position valid flag dropped")
    `PPC_ASSERT(a_fresh_sets_valid, (res_valid && fresh) |=> valid_flag_reg, "commit missed")
    `PPC_ASSERT_ALWAYS(a_count_monotonic, rst_n |=> (!rst_n || fail_count_reg >= $past(fail_count_reg)), "fail counter decreased")

endmodule

@@ tb/sv/tb_position_packet_checker.sv @@
`timescale 1ns / 100ps

module tb_position_packet_checker;

    import ppc_pkg::*;

    localparam int FRAME_LEN      = FRAME_BYTES_DEFAULT;
    localparam int ITEM_GOAL      = 1600;
    localparam int TAIL_ITEMS     = 160;
    localparam int PRESSURE_AFTER = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    // ways to spoil an otherwise good frame
    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_ADDR,
        FLAW_TYPE_LO,
        FLAW_TYPE_HI,
        FLAW_SIZE,
        FLAW_CHECKSUM
    } flaw_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_item_t byte_item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;

    // items waiting to be offered, and frame results waiting to be seen
    byte_item_t byte_backlog[$];
    result_t    frame_results_due[$];

    int bytes_total;
    int bytes_accepted;
    int results_seen;
    int mismatches;
    int status_seen[5];
    int send_gap;
    int stall_left;
    int hold_left;
    int idle_cycles;
    bit pressure_done;
    bit tail_phase = 1'b0;

    // predictor state: frame position, running checksum, captured fields
    int          frame_pos = 0;
    logic [15:0] crc_acc = CRC_INIT;
    bit          short_ok = 1'b0;
    bit          long_ok = 1'b0;
    logic [7:0]  hdr_seen[HEADER_LEN];
    logic [7:0]  coord_raw[Z_LAST - X_FIRST + 1];
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] pos_z = '0;
    bit          pos_valid = 1'b0;
    logic [7:0]  bad_byte = '0;
    logic [31:0] fail_cnt = '0;

    position_packet_checker #(
        .FRAME_BYTES (FRAME_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-16, fed one bit at a time (LSB first).
    function automatic logic [15:0] crc_feed(logic [15:0] acc, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // Draw a coordinate, biased toward the edges of its range.
    function automatic logic [31:0] coordinate_draw(bit mm_format);
        logic [31:0] mask;
        logic [31:0] v;
        mask = mm_format ? 32'hffff_ffff : 32'h0000_ffff;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 32'hffff_ffff;
            2: v = 32'h8000_0000;
            3: v = 32'h7fff_ffff;
            default: v = $urandom;
        endcase
        return v & mask;
    endfunction

    // Advance the predicted frame by one accepted item; queue a result at frame end.
    task automatic absorb_byte(input byte_item_t it);
        int          idx;
        logic [7:0]  b;
        status_t     st;
        bit          fresh;
        result_t     r;
        b   = it.data_byte;
        idx = it.frame_start ? 0 : frame_pos;
        if (idx == 0)
        begin
            crc_acc  = CRC_INIT;
            short_ok = 1'b0;
            long_ok  = 1'b0;
        end
        crc_acc = crc_feed(crc_acc, b);
        if (idx + 1 == SHORT_SPAN)
            short_ok = (crc_acc == 16'h0000);
        if (idx + 1 == LONG_SPAN)
            long_ok = (crc_acc == 16'h0000);
        if (idx < HEADER_LEN)
            hdr_seen[idx] = b;
        else if (idx >= X_FIRST && idx <= Z_LAST)
            coord_raw[idx - X_FIRST] = b;
        if (idx + 1 < FRAME_LEN)
        begin
            frame_pos = idx + 1;
            return;
        end
        frame_pos = 0;

        // checks run in a fixed order: header, packet type, size, checksum
        st    = ST_OK;
        fresh = 1'b0;
        if (hdr_seen[0] != HDR_SYNC || hdr_seen[1] != HDR_ADDR)
        begin
            st       = ST_HEADER;
            bad_byte = hdr_seen[1];
        end
        else if (!(hdr_seen[2] == TYPE_LO_A || hdr_seen[2] == TYPE_LO_B)
                 || hdr_seen[3] != TYPE_HI)
        begin
            st       = ST_TYPE;
            bad_byte = hdr_seen[2];
        end
        else if (hdr_seen[4] == SIZE_CM)
        begin
            if (short_ok)
            begin
                // centimetre values, unsigned 16 bit, scaled to millimetres
                pos_x = 32'({coord_raw[1], coord_raw[0]}) * 32'd10;
                pos_y = 32'({coord_raw[3], coord_raw[2]}) * 32'd10;
                pos_z = 32'({coord_raw[5], coord_raw[4]}) * 32'd10;
                fresh = 1'b1;
            end
            else
                st = ST_CRC;
        end
        else if (hdr_seen[4] == SIZE_MM)
        begin
            if (long_ok)
            begin
                pos_x = {coord_raw[3], coord_raw[2], coord_raw[1], coord_raw[0]};
                pos_y = {coord_raw[7], coord_raw[6], coord_raw[5], coord_raw[4]};
                pos_z = {coord_raw[11], coord_raw[10], coord_raw[9], coord_raw[8]};
                fresh = 1'b1;
            end
            else
                st = ST_CRC;
        end
        else
        begin
            st       = ST_SIZE;
            bad_byte = hdr_seen[4];
        end

        if (fresh)
            pos_valid = 1'b1;
        // saturate rather than wrap; the top is far out of reach in one run
        if (st != ST_OK && fail_cnt != 32'hffff_ffff)
            fail_cnt = fail_cnt + 32'd1;

        r.status         = st;
        r.pos_x_mm       = pos_x;
        r.pos_y_mm       = pos_y;
        r.pos_z_mm       = pos_z;
        r.position_fresh = fresh;
        r.position_valid = pos_valid;
        r.offending_byte = bad_byte;
        r.failure_count  = fail_cnt;
        frame_results_due.push_back(r);
    endtask

    // Build one frame, optionally spoiled, and queue its first `keep` bytes.
    task automatic emit_frame(input bit mm_format, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input flaw_t flaw, input bit with_start, input int keep);
        logic [7:0]  fr[FRAME_LEN];
        logic [15:0] crc;
        logic [7:0]  v;
        int          span;
        int          at;
        byte_item_t  it;
        for (int i = 0; i < FRAME_LEN; i++)
            fr[i] = 8'($urandom);
        fr[0] = HDR_SYNC;
        fr[1] = HDR_ADDR;
        fr[2] = $urandom_range(0, 1) ? TYPE_LO_A : TYPE_LO_B;
        fr[3] = TYPE_HI;
        fr[4] = mm_format ? SIZE_MM : SIZE_CM;
        if (mm_format)
        begin
            {fr[12], fr[11], fr[10], fr[9]}  = x;
            {fr[16], fr[15], fr[14], fr[13]} = y;
            {fr[20], fr[19], fr[18], fr[17]} = z;
        end
        else
        begin
            {fr[10], fr[9]}  = x[15:0];
            {fr[12], fr[11]} = y[15:0];
            {fr[14], fr[13]} = z[15:0];
        end

        // spoil the header before the checksum so only the header is wrong
        v = 8'($urandom);
        case (flaw)
            FLAW_SYNC:
                fr[0] = (v == HDR_SYNC) ? 8'h00 : v;
            FLAW_ADDR:
                fr[1] = (v == HDR_ADDR) ? 8'h46 : v;
            FLAW_TYPE_LO:
                fr[2] = (v == TYPE_LO_A || v == TYPE_LO_B) ? 8'h02 : v;
            FLAW_TYPE_HI:
                fr[3] = (v == TYPE_HI) ? 8'hff : v;
            FLAW_SIZE:
                fr[4] = (v == SIZE_CM || v == SIZE_MM) ? 8'h00 : v;
            default:
                ;
        endcase

        // checksum goes last in the span, low byte first
        span = mm_format ? LONG_SPAN : SHORT_SPAN;
        crc  = CRC_INIT;
        for (int i = 0; i < span - 2; i++)
            crc = crc_feed(crc, fr[i]);
        fr[span - 2] = crc[7:0];
        fr[span - 1] = crc[15:8];

        // one flipped bit past the header always breaks the checksum
        if (flaw == FLAW_CHECKSUM)
        begin
            at     = $urandom_range(HEADER_LEN, span - 1);
            fr[at] = fr[at] ^ (8'h01 << $urandom_range(0, 7));
        end

        for (int i = 0; i < keep; i++)
        begin
            it.data_byte   = fr[i];
            it.frame_start = with_start && (i == 0);
            byte_backlog.push_back(it);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Driver: offer backlog items, hold them while stalled, insert idle bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                absorb_byte(byte_item);
                bytes_accepted++;
            end
            if (byte_valid && byte_stall)
            begin
                // hold the stalled item as it is
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                byte_valid <= 1'b0;
            end
            else if (byte_backlog.size() != 0)
            begin
                byte_valid <= 1'b1;
                byte_item  <= byte_backlog.pop_front();
                if (byte_backlog.size() < TAIL_ITEMS)
                    tail_phase <= 1'b1;
                else if ($urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted result against the oldest prediction,
    // then decide the stall for the next cycle.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (result.status <= ST_CRC)
                    status_seen[result.status]++;
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("pos_x_mm", want.pos_x_mm, result.pos_x_mm);
                    check_field("pos_y_mm", want.pos_y_mm, result.pos_y_mm);
                    check_field("pos_z_mm", want.pos_z_mm, result.pos_z_mm);
                    check_field("position_fresh", 32'(want.position_fresh),
                                32'(result.position_fresh));
                    check_field("position_valid", 32'(want.position_valid),
                                32'(result.position_valid));
                    check_field("offending_byte", 32'(want.offending_byte),
                                32'(result.offending_byte));
                    check_field("failure_count", want.failure_count,
                                result.failure_count);
                end
            end

            // one long hold early on fills the output queue and backs up the input
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!pressure_done && results_seen >= PRESSURE_AFTER)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("position_packet_checker verification failed");
                $finish;
            end
            else
                idle_cycles++;
        end
    end

    initial
    begin
        bit          aligned;
        bit          mm_format;
        bit          with_start;
        int          pick;
        int          noise_len;
        int          goal;
        byte_item_t  it;

        // Directed frames. The first one carries no start flag: the first byte
        // after reset must still count as byte 0.
        emit_frame(1'b0, 32'hffff, 32'hffff, 32'hffff, FLAW_NONE, 1'b0, FRAME_LEN);
        emit_frame(1'b0, 32'h0, 32'h0, 32'h0, FLAW_NONE, 1'b1, FRAME_LEN);
        emit_frame(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, FLAW_NONE,
                   1'b1, FRAME_LEN);
        // back to back, no start flag: the next frame begins right after the last
        emit_frame(1'b1, 32'h0, 32'h1, 32'hffff_fffe, FLAW_NONE, 1'b0, FRAME_LEN);
        // every failure kind, the checksum one twice; crc failures must leave the offending byte alone
        for (int f = FLAW_SYNC; f <= FLAW_CHECKSUM; f++)
            emit_frame(f[0], $urandom, $urandom, $urandom, flaw_t'(f), 1'b1, FRAME_LEN);
        emit_frame(1'b0, $urandom, $urandom, $urandom, FLAW_CHECKSUM, 1'b1, FRAME_LEN);
        // failed frames keep the committed position
        emit_frame(1'b1, 32'h1234_5678, 32'hfedc_ba98, 32'h0, FLAW_NONE, 1'b1, FRAME_LEN);
        emit_frame(1'b1, $urandom, $urandom, $urandom, FLAW_SIZE, 1'b1, FRAME_LEN);
        // a start flag mid-frame drops the partial frame, including one byte short
        emit_frame(1'b1, $urandom, $urandom, $urandom, FLAW_NONE, 1'b1, 12);
        emit_frame(1'b0, $urandom, $urandom, $urandom, FLAW_NONE, 1'b1, FRAME_LEN - 1);
        emit_frame(1'b0, 32'h1, 32'h8000, 32'h7fff, FLAW_NONE, 1'b1, FRAME_LEN);

        // Random part: mostly well-formed frames with random content, the rest
        // spoiled frames, cut-off frames and raw noise.
        aligned = 1'b1;
        goal    = ITEM_GOAL;
        while (byte_backlog.size() < goal)
        begin
            pick       = $urandom_range(0, 99);
            mm_format  = 1'($urandom_range(0, 1));
            with_start = aligned ? ($urandom_range(0, 3) != 0) : 1'b1;
            if (pick < 68)
            begin
                emit_frame(mm_format, coordinate_draw(mm_format), coordinate_draw(mm_format),
                           coordinate_draw(mm_format), FLAW_NONE, with_start, FRAME_LEN);
                aligned = 1'b1;
            end
            else if (pick < 86)
            begin
                emit_frame(mm_format, $urandom, $urandom, $urandom,
                           flaw_t'($urandom_range(FLAW_SYNC, FLAW_CHECKSUM)),
                           with_start, FRAME_LEN);
                aligned = 1'b1;
            end
            else if (pick < 94)
            begin
                emit_frame(mm_format, $urandom, $urandom, $urandom, FLAW_NONE, 1'b1,
                           $urandom_range(1, FRAME_LEN - 1));
                aligned = 1'b0;
            end
            else
            begin
                noise_len = $urandom_range(1, 40);
                for (int i = 0; i < noise_len; i++)
                begin
                    it.data_byte   = 8'($urandom);
                    it.frame_start = ($urandom_range(0, 7) == 0);
                    byte_backlog.push_back(it);
                end
                aligned = 1'b0;
            end
        end
        bytes_total = byte_backlog.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every item taken, every predicted result seen, then an idle drain period
        while (bytes_accepted != bytes_total)
            @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += frame_results_due.size();

        $display("Covered %0d bytes giving %0d frame results: %0d ok, %0d header, %0d type,",
                 bytes_total, results_seen, status_seen[ST_OK], status_seen[ST_HEADER],
                 status_seen[ST_TYPE]);
        $display("%0d size and %0d crc errors, with restarts, noise and a long output hold.",
                 status_seen[ST_SIZE], status_seen[ST_CRC]);
        if (mismatches == 0)
            $display("position_packet_checker verification clean");
        else
            $display("position_packet_checker verification failed");
        $finish;
    end

endmodule
